### sv/checked_int_alu_float_divide_top_macros.svh
// Assertion macros used by the checked ALU top level.
`ifndef CHECKED_INT_ALU_FLOAT_DIVIDE_TOP_MACROS_SVH
`define CHECKED_INT_ALU_FLOAT_DIVIDE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CIA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define CIA_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define CIA_ASSERT_IMPL(lbl, ante, cons)
`define CIA_ASSERT_NEVER(lbl, expr)
`endif
`endif

### sv/cia_pkg.sv
// Types, codes and helper functions of the checked ALU.
package cia_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OVF     = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;
	localparam logic [1:0] ST_BADOP   = 2'd3;

	// One quotient bit per stage: 24 mantissa bits and a guard bit.
	localparam int DIV_STEPS = 25;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  status;
		logic [31:0] ires;
		logic        sgn;
		logic        az;
		logic [31:0] ma;
		logic [31:0] mb;
		logic [4:0]  la;
		logic [4:0]  lb;
		logic [31:0] pll;
		logic [31:0] plh;
		logic [31:0] phl;
		logic [31:0] phh;
		logic [63:0] prod;
	} norm_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  status;
		logic [31:0] ires;
		logic        sgn;
		logic        az;
		logic [7:0]  expo;
		logic [24:0] rem;
		logic [23:0] dv;
		logic [24:0] q;
	} div_t;

	typedef struct packed {
		logic [5:0]  e;
		logic [23:0] m;
	} fp24_t;

	// Rounds a normalized 32-bit magnitude to a 24-bit mantissa, nearest even.
	function automatic fp24_t to_fp24(input logic [31:0] m, input logic [4:0] lz);
		fp24_t r;
		logic [24:0] s;
		logic inc;
		inc = m[7] & ((|m[6:0]) | m[8]);
		s = {1'b0, m[31:8]} + {24'h0, inc};
		r.e = 6'd31 - {1'b0, lz} + {5'h0, s[24]};
		r.m = s[24] ? s[24:1] : s[23:0];
		return r;
	endfunction

endpackage

### sv/cia_norm.sv
// Front pipeline: add/subtract, split multiply, and leading-zero normalization.
module cia_norm import cia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_vld,
	input  logic [2:0]  in_op,
	input  logic [31:0] in_a,
	input  logic [31:0] in_b,
	output logic        out_vld,
	output norm_t       out_item
);

	norm_t d1, d2, d3, d4, d5, d6;
	norm_t item_s1, item_s2, item_s3, item_s4, item_s5, item_s6;
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [32:0] sum, dif;
	logic ovf;

	always_comb begin
		sum = {in_a[31], in_a} + {in_b[31], in_b};
		dif = {in_a[31], in_a} - {in_b[31], in_b};
		d1 = '0;
		d1.op = in_op;
		d1.sgn = in_a[31] ^ in_b[31];
		d1.az = (in_a == 32'h0);
		d1.ma = in_a[31] ? (~in_a + 32'd1) : in_a;
		d1.mb = in_b[31] ? (~in_b + 32'd1) : in_b;
		case (in_op)
			OP_ADD: begin
				d1.status = (sum[32] != sum[31]) ? ST_OVF : ST_OK;
				d1.ires = (sum[32] != sum[31]) ? 32'h0 : sum[31:0];
			end
			OP_SUB: begin
				d1.status = (dif[32] != dif[31]) ? ST_OVF : ST_OK;
				d1.ires = (dif[32] != dif[31]) ? 32'h0 : dif[31:0];
			end
			OP_MUL: d1.status = ST_OK;
			OP_DIV: d1.status = (in_b == 32'h0) ? ST_DIVZERO : ST_OK;
			default: d1.status = ST_BADOP;
		endcase
	end

	always_comb begin
		d2 = item_s1;
		d2.pll = item_s1.ma[15:0] * item_s1.mb[15:0];
		d2.plh = item_s1.ma[15:0] * item_s1.mb[31:16];
		d2.phl = item_s1.ma[31:16] * item_s1.mb[15:0];
		d2.phh = item_s1.ma[31:16] * item_s1.mb[31:16];
		if (item_s1.ma[31:16] == 16'h0) begin
			d2.ma = {item_s1.ma[15:0], 16'h0};
			d2.la = 5'd16;
		end
		if (item_s1.mb[31:16] == 16'h0) begin
			d2.mb = {item_s1.mb[15:0], 16'h0};
			d2.lb = 5'd16;
		end
	end

	always_comb begin
		d3 = item_s2;
		d3.prod = {item_s2.phh, item_s2.pll} + {16'h0, item_s2.plh, 16'h0};
		if (item_s2.ma[31:24] == 8'h0) begin
			d3.ma = {item_s2.ma[23:0], 8'h0};
			d3.la = item_s2.la | 5'd8;
		end
		if (item_s2.mb[31:24] == 8'h0) begin
			d3.mb = {item_s2.mb[23:0], 8'h0};
			d3.lb = item_s2.lb | 5'd8;
		end
	end

	always_comb begin
		d4 = item_s3;
		d4.prod = item_s3.prod + {16'h0, item_s3.phl, 16'h0};
		if (item_s3.ma[31:28] == 4'h0) begin
			d4.ma = {item_s3.ma[27:0], 4'h0};
			d4.la = item_s3.la | 5'd4;
		end
		if (item_s3.mb[31:28] == 4'h0) begin
			d4.mb = {item_s3.mb[27:0], 4'h0};
			d4.lb = item_s3.lb | 5'd4;
		end
	end

	always_comb begin
		d5 = item_s4;
		// A negative product may reach exactly two to the 31st.
		if (item_s4.sgn)
			ovf = !((item_s4.prod[63:31] == 33'h0) || (item_s4.prod == 64'h8000_0000));
		else
			ovf = (item_s4.prod[63:31] != 33'h0);
		if (item_s4.op == OP_MUL) begin
			d5.status = ovf ? ST_OVF : ST_OK;
			if (ovf)
				d5.ires = 32'h0;
			else
				d5.ires = item_s4.sgn ? (~item_s4.prod[31:0] + 32'd1) : item_s4.prod[31:0];
		end
		if (item_s4.ma[31:30] == 2'h0) begin
			d5.ma = {item_s4.ma[29:0], 2'h0};
			d5.la = item_s4.la | 5'd2;
		end
		if (item_s4.mb[31:30] == 2'h0) begin
			d5.mb = {item_s4.mb[29:0], 2'h0};
			d5.lb = item_s4.lb | 5'd2;
		end
	end

	always_comb begin
		d6 = item_s5;
		if (!item_s5.ma[31]) begin
			d6.ma = {item_s5.ma[30:0], 1'b0};
			d6.la = item_s5.la | 5'd1;
		end
		if (!item_s5.mb[31]) begin
			d6.mb = {item_s5.mb[30:0], 1'b0};
			d6.lb = item_s5.lb | 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= d1;
			item_s2 <= d2;
			item_s3 <= d3;
			item_s4 <= d4;
			item_s5 <= d5;
			item_s6 <= d6;
		end
	end

	assign out_vld  = vld_s6;
	assign out_item = item_s6;

endmodule

### sv/cia_div.sv
// Back pipeline: mantissa rounding, bit-per-stage divider and result packing.
module cia_div import cia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_vld,
	input  norm_t       in_item,
	output logic        out_vld,
	output logic [1:0]  out_status,
	output logic [31:0] out_ires,
	output logic [31:0] out_fres,
	output logic        out_isf
);

	div_t  prep;
	fp24_t fa, fb;
	logic  pre;
	logic [8:0] exp9;
	div_t  div_s [DIV_STEPS+1];
	logic  dvld_s [DIV_STEPS+1];
	div_t  last;
	logic  sticky, inc, ok;
	logic [24:0] m25;
	logic [7:0]  e_fin;
	logic [1:0]  status_s34;
	logic [31:0] ires_s34, fres_s34;
	logic        isf_s34, vld_s34;

	always_comb begin
		fa = to_fp24(in_item.ma, in_item.la);
		fb = to_fp24(in_item.mb, in_item.lb);
		pre = (fa.m < fb.m);
		exp9 = 9'd127 + {3'h0, fa.e} - {3'h0, fb.e} - {8'h0, pre};
		prep.op = in_item.op;
		prep.status = in_item.status;
		prep.ires = in_item.ires;
		prep.sgn = in_item.sgn;
		prep.az = in_item.az;
		prep.expo = exp9[7:0];
		// Bring the mantissa ratio into [1, 2) before the first step.
		prep.rem = pre ? {fa.m, 1'b0} : {1'b0, fa.m};
		prep.dv = fb.m;
		prep.q = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dvld_s[0] <= 1'b0;
		else if (adv)
			dvld_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (adv)
			div_s[0] <= prep;
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		div_t nx;
		logic [24:0] diff;
		logic qb;

		always_comb begin
			nx = div_s[i];
			qb = (div_s[i].rem >= {1'b0, div_s[i].dv});
			diff = qb ? (div_s[i].rem - {1'b0, div_s[i].dv}) : div_s[i].rem;
			nx.rem = {diff[23:0], 1'b0};
			nx.q = {div_s[i].q[23:0], qb};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dvld_s[i+1] <= 1'b0;
			else if (adv)
				dvld_s[i+1] <= dvld_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv)
				div_s[i+1] <= nx;
		end
	end

	always_comb begin
		last = div_s[DIV_STEPS];
		sticky = |last.rem;
		inc = last.q[0] & (sticky | last.q[1]);
		m25 = {1'b0, last.q[24:1]} + {24'h0, inc};
		e_fin = last.expo + {7'h0, m25[24]};
		ok = (last.op == OP_DIV) && (last.status == ST_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s34 <= 1'b0;
		else if (adv)
			vld_s34 <= dvld_s[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s34 <= last.status;
			ires_s34 <= last.ires;
			isf_s34 <= ok;
			if (!ok)
				fres_s34 <= 32'h0;
			else if (last.az)
				fres_s34 <= {last.sgn, 31'h0};
			else
				fres_s34 <= {last.sgn, e_fin, m25[22:0]};
		end
	end

	assign out_vld    = vld_s34;
	assign out_status = status_s34;
	assign out_ires   = ires_s34;
	assign out_fres   = fres_s34;
	assign out_isf    = isf_s34;

endmodule

### sv/checked_int_alu_float_divide_top.sv
// Checked integer ALU with single-precision divide: top level.
//
// Request channel: req_valid, req_stall, req_type, operand_a, operand_b.
// Response channel: rsp_valid, rsp_stall, status, int_result, float_result, is_float.
// A transaction moves on a rising edge where valid is high and stall is low.
// Add, subtract and multiply give a checked 32-bit result; divide converts both
// operands to single precision and gives the rounded single quotient.
// Every request yields exactly one response, in order.
// The pipeline has six front stages (add/subtract, a multiply split in
// 16-bit partial products, leading-zero normalization), one rounding stage,
// 25 divider stages retiring one quotient bit each, and the output register.
// One transaction per cycle unless a response stalls; all stages advance together.
// When the receiver stalls a valid response, every stage holds and req_stall
// rises in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits; the block accepts requests right after reset.
`include "checked_int_alu_float_divide_top_macros.svh"
module checked_int_alu_float_divide_top import cia_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic signed [31:0] int_result,
	output logic [31:0]        float_result,
	output logic               is_float
);

	logic  adv;
	logic  mid_vld;
	norm_t mid_item;

	assign adv = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	cia_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (req_valid),
		.in_op    (req_type),
		.in_a     (operand_a),
		.in_b     (operand_b),
		.out_vld  (mid_vld),
		.out_item (mid_item)
	);

	cia_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_vld     (mid_vld),
		.in_item    (mid_item),
		.out_vld    (rsp_valid),
		.out_status (status),
		.out_ires   (int_result),
		.out_fres   (float_result),
		.out_isf    (is_float)
	);

	`CIA_ASSERT_IMPL(a_float_ok, rsp_valid && is_float, status == ST_OK && int_result == 32'sd0)
	`CIA_ASSERT_IMPL(a_err_zero, rsp_valid && status != ST_OK, int_result == 32'sd0 && float_result == 32'h0 && !is_float)
	`CIA_ASSERT_NEVER(a_float_nonzero, rsp_valid && !is_float && float_result != 32'h0)

endmodule
